// ----- rtl/jet_pkg.sv -----
// ----------------------------------------------------------------------------
// jet_pkg: shared types and constants of the Julia escape-time pixel engine
// Fixed-point format, field widths, register indexes, datapath command codes
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package jet_pkg;

	// frame and arithmetic limits
	localparam int MAX_DIM    = 1024;
	localparam int FRAC_BITS  = 28;
	localparam int ITER_LIMIT = 1000;

	// field widths
	localparam int COORD_W = 10;
	localparam int CNT_W   = 10;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_C_REAL   = 3'd0;
	localparam logic [IDX_W-1:0] REG_C_IMAG   = 3'd1;
	localparam logic [IDX_W-1:0] REG_X_MIN    = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_MIN    = 3'd3;
	localparam logic [IDX_W-1:0] REG_X_STEP   = 3'd4;
	localparam logic [IDX_W-1:0] REG_Y_STEP   = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd6;

	// shared multiplier operand selects
	localparam logic [2:0] MUL_COLX = 3'd0;
	localparam logic [2:0] MUL_ROWY = 3'd1;
	localparam logic [2:0] MUL_XY   = 3'd2;
	localparam logic [2:0] MUL_XX   = 3'd3;
	localparam logic [2:0] MUL_YY   = 3'd4;

	// configuration register file contents
	typedef struct packed {
		logic signed [29:0] c_real;
		logic signed [29:0] c_imag;
		logic signed [31:0] x_min;
		logic signed [31:0] y_min;
		logic [30:0]        x_step;
		logic [30:0]        y_step;
		logic [CNT_W-1:0]   limit;   // max_iter clamped to ITER_LIMIT
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic       load_in;   // latch clamped col/row
		logic       mul_en;    // capture a product
		logic [2:0] mul_op;    // operand select
		logic       set_zr;    // zr from x_min + product
		logic       set_zi;    // zi from y_min + product, loop init
		logic       cap_cross; // cross term from product
		logic       cap_xx;    // real square from product
		logic       step;      // apply one z <- z*z + c update
		logic       load_out;  // load the output count register
		logic       out_zero;  // loaded count is zero (bounded)
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic escaped;
		logic at_limit;
	} status_t;

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/jet_if.sv -----
// ----------------------------------------------------------------------------
// jet_if: stream channels of the pixel engine
// Pixel coordinate channel and iteration count channel, valid/ready.
// ----------------------------------------------------------------------------
interface jet_pix_if;
	logic                         valid;
	logic                         ready;
	logic [jet_pkg::COORD_W-1:0]  col;
	logic [jet_pkg::COORD_W-1:0]  row;

	modport source(output valid, output col, output row, input ready);
	modport sink(input valid, input col, input row, output ready);
endinterface

interface jet_cnt_if;
	logic                       valid;
	logic                       ready;
	logic [jet_pkg::CNT_W-1:0]  iteration_count;

	modport source(output valid, output iteration_count, input ready);
	modport sink(input valid, input iteration_count, output ready);
endinterface

// ----- rtl/julia_escape_time_pixel.sv -----
// ----------------------------------------------------------------------------
// julia_escape_time_pixel: Julia-set escape-time count per pixel
// An accepted pixel walks start-point setup, then loop passes until it escapes
// or reaches the limit; its count is loaded once the output register is free.
// One pixel at a time: no new pixel is taken until the last count is loaded.
// Each pass of the loop runs three products through the one shared multiplier.
// Reset: asynchronous active-low, returns to idle with config registers at defaults.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [jet_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [jet_pkg::CFG_W-1:0]   cfg_data,
	jet_pix_if.sink                     pix_in,
	jet_cnt_if.source                   cnt_out
);

	jet_pkg::cfg_t    cfg;
	jet_pkg::cmd_t    cmd;
	jet_pkg::status_t status;

	// configuration registers
	jet_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// sequencer
	jet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.out_valid (cnt_out.valid),
		.out_ready (cnt_out.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	jet_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.col    (pix_in.col),
		.row    (pix_in.row),
		.status (status),
		.count  (cnt_out.iteration_count)
	);

	// a result is loaded only into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!cnt_out.valid || cnt_out.ready))
		else $error("result loaded over a pending beat");

	// a loaded result shows up as a beat
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> cnt_out.valid)
		else $error("loaded result not presented");

	// one pixel at a time: no accept right after an accept
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready) |=> !pix_in.ready)
		else $error("input accepted while busy");

	// an update step never runs at or past the limit
	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!status.at_limit && !status.escaped))
		else $error("update step past loop exit");

endmodule

// ----- rtl/jet_cfg.sv -----
// ----------------------------------------------------------------------------
// jet_cfg: configuration register file
// Decodes register writes, holds reset values, clamps the iteration limit.
// ----------------------------------------------------------------------------
module jet_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [jet_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [jet_pkg::CFG_W-1:0]   cfg_data,
	output jet_pkg::cfg_t               cfg
);

	logic signed [29:0]          c_real_q;
	logic signed [29:0]          c_imag_q;
	logic signed [31:0]          x_min_q;
	logic signed [31:0]          y_min_q;
	logic [30:0]                 x_step_q;
	logic [30:0]                 y_step_q;
	logic [jet_pkg::CNT_W-1:0]   max_iter_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q   <= 30'sd80530637;
			c_imag_q   <= 30'sd134217728;
			x_min_q    <= -32'sd268435456;
			y_min_q    <= -32'sd268435456;
			x_step_q   <= 31'd1050628;
			y_step_q   <= 31'd1050628;
			max_iter_q <= 10'd200;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				jet_pkg::REG_C_REAL:   c_real_q   <= cfg_data[29:0];
				jet_pkg::REG_C_IMAG:   c_imag_q   <= cfg_data[29:0];
				jet_pkg::REG_X_MIN:    x_min_q    <= cfg_data;
				jet_pkg::REG_Y_MIN:    y_min_q    <= cfg_data;
				jet_pkg::REG_X_STEP:   x_step_q   <= cfg_data[30:0];
				jet_pkg::REG_Y_STEP:   y_step_q   <= cfg_data[30:0];
				jet_pkg::REG_MAX_ITER: max_iter_q <= cfg_data[jet_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// outputs, limit clamped to the build-time ceiling
	always_comb begin
		cfg.c_real = c_real_q;
		cfg.c_imag = c_imag_q;
		cfg.x_min  = x_min_q;
		cfg.y_min  = y_min_q;
		cfg.x_step = x_step_q;
		cfg.y_step = y_step_q;
		if (32'(max_iter_q) > 32'(jet_pkg::ITER_LIMIT)) begin
			cfg.limit = jet_pkg::CNT_W'(jet_pkg::ITER_LIMIT);
		end else begin
			cfg.limit = max_iter_q;
		end
	end

endmodule

// ----- rtl/jet_dp.sv -----
// ----------------------------------------------------------------------------
// jet_dp: escape-time datapath
// One shared signed 32x32 multiplier with a product register, z registers,
// square/cross term registers, iteration counter and output count register.
// ----------------------------------------------------------------------------
module jet_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jet_pkg::cfg_t               cfg,
	input  jet_pkg::cmd_t               cmd,
	input  logic [jet_pkg::COORD_W-1:0] col,
	input  logic [jet_pkg::COORD_W-1:0] row,
	output jet_pkg::status_t            status,
	output logic [jet_pkg::CNT_W-1:0]   count
);

	localparam logic [jet_pkg::COORD_W-1:0] DIM_TOP =
		jet_pkg::COORD_W'(jet_pkg::MAX_DIM - 1);
	localparam logic signed [63:0] FOUR = 64'sd4 <<< jet_pkg::FRAC_BITS;

	logic [jet_pkg::COORD_W-1:0] col_q;
	logic [jet_pkg::COORD_W-1:0] row_q;
	logic signed [63:0]          prod_q;
	logic signed [31:0]          zr_q;
	logic signed [31:0]          zi_q;
	logic signed [63:0]          xx_q;
	logic signed [63:0]          cross_q;
	logic                        swap_q;
	logic [jet_pkg::CNT_W-1:0]   n_q;
	logic [jet_pkg::CNT_W-1:0]   cnt_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] yy;
	logic signed [63:0] add_r;
	logic signed [63:0] add_i;

	// latch the pixel index, clamped to the frame
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			col_q <= (32'(col) >= 32'(jet_pkg::MAX_DIM)) ? DIM_TOP : col;
			row_q <= (32'(row) >= 32'(jet_pkg::MAX_DIM)) ? DIM_TOP : row;
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (cmd.mul_op)
			jet_pkg::MUL_COLX: begin
				mul_a = $signed({{(32-jet_pkg::COORD_W){1'b0}}, col_q});
				mul_b = $signed({1'b0, cfg.x_step});
			end
			jet_pkg::MUL_ROWY: begin
				mul_a = $signed({{(32-jet_pkg::COORD_W){1'b0}}, row_q});
				mul_b = $signed({1'b0, cfg.y_step});
			end
			jet_pkg::MUL_XY: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			jet_pkg::MUL_XX: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			jet_pkg::MUL_YY: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// escape test and update terms; c alternates between (im, re) and (re, im)
	always_comb begin
		yy    = prod_q >>> jet_pkg::FRAC_BITS;
		add_r = swap_q ? 64'(cfg.c_real) : 64'(cfg.c_imag);
		add_i = swap_q ? 64'(cfg.c_imag) : 64'(cfg.c_real);
		status.escaped  = (xx_q + yy) > FOUR;
		status.at_limit = n_q >= cfg.limit;
	end

	// z registers, squared/cross terms and output count register
	always_ff @(posedge clk) begin
		if (cmd.set_zr) begin
			zr_q <= jet_pkg::sat32(64'(cfg.x_min) + prod_q);
		end else if (cmd.step) begin
			zr_q <= jet_pkg::sat32(xx_q - yy + add_r);
		end
		if (cmd.set_zi) begin
			zi_q <= jet_pkg::sat32(64'(cfg.y_min) + prod_q);
		end else if (cmd.step) begin
			zi_q <= jet_pkg::sat32(cross_q + add_i);
		end
		if (cmd.cap_cross) begin
			cross_q <= prod_q >>> (jet_pkg::FRAC_BITS - 1);
		end
		if (cmd.cap_xx) begin
			xx_q <= prod_q >>> jet_pkg::FRAC_BITS;
		end
		if (cmd.load_out) begin
			cnt_q <= cmd.out_zero ? '0 : n_q;
		end
	end

	// iteration counter and c swap phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			swap_q <= 1'b0;
		end else if (cmd.set_zi) begin
			n_q    <= '0;
			swap_q <= 1'b0;
		end else if (cmd.step) begin
			n_q    <= n_q + 1'b1;
			swap_q <= ~swap_q;
		end
	end

	assign count = cnt_q;

endmodule

// ----- rtl/jet_ctrl.sv -----
// ----------------------------------------------------------------------------
// jet_ctrl: escape-time sequencer
// Walks start-point setup and iteration passes (PXY, PXX, PYY, EVAL), issues
// datapath commands and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module jet_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  jet_pkg::status_t    status,
	output jet_pkg::cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MX   = 3'd1;
	localparam logic [2:0] ST_MY   = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_PXY  = 3'd4;
	localparam logic [2:0] ST_PXX  = 3'd5;
	localparam logic [2:0] ST_PYY  = 3'd6;
	localparam logic [2:0] ST_EVAL = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       finish;

	assign out_free = !out_valid_q || out_ready;
	assign finish   = status.escaped || status.at_limit;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_MX;
				end
			end
			ST_MX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = jet_pkg::MUL_COLX;
				state_d    = ST_MY;
			end
			ST_MY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = jet_pkg::MUL_ROWY;
				cmd.set_zr = 1'b1;
				state_d    = ST_INIT;
			end
			ST_INIT: begin
				cmd.set_zi = 1'b1;
				state_d    = ST_PXY;
			end
			ST_PXY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = jet_pkg::MUL_XY;
				state_d    = ST_PXX;
			end
			ST_PXX: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_op    = jet_pkg::MUL_XX;
				cmd.cap_cross = 1'b1;
				state_d       = ST_PYY;
			end
			ST_PYY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = jet_pkg::MUL_YY;
				cmd.cap_xx = 1'b1;
				state_d    = ST_EVAL;
			end
			ST_EVAL: begin
				// escape wins over the limit; hold here while the output is full
				if (finish) begin
					if (out_free) begin
						cmd.load_out = 1'b1;
						cmd.out_zero = !status.escaped;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_PXY;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench of the Julia escape-time pixel engine
// Pixel beats go in on a valid/ready channel and iteration counts come back on
// another. A local escape-time predictor, fed from a shadow copy of the config
// registers, computes each count as its pixel is accepted. The monitor checks
// every count beat in order. A directed table runs first, then random frames
// under changing back-pressure, with the config rewritten while the engine is
// idle.
// ----------------------------------------------------------------------------
module tb;

	localparam int     STALL_LIMIT = 20000;   // cycles with no beat at all
	localparam int     Q_ONE       = 268435456;
	localparam int     Q_TWO       = 536870912;
	localparam longint S32_MAX     = 64'sd2147483647;
	localparam longint S32_MIN     = -64'sd2147483648;
	localparam logic [jet_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [jet_pkg::IDX_W-1:0]   idx;
		logic [jet_pkg::CFG_W-1:0]   data;
		logic [jet_pkg::COORD_W-1:0] col;
		logic [jet_pkg::COORD_W-1:0] row;
		logic                        typed;   // count below is fixed, not predicted
		logic [jet_pkg::CNT_W-1:0]   count;
	} dir_row_t;

	typedef struct packed {
		logic [jet_pkg::COORD_W-1:0] col;
		logic [jet_pkg::COORD_W-1:0] row;
		logic [jet_pkg::CNT_W-1:0]   count;
	} pixel_count_t;

	typedef struct packed {
		logic signed [29:0]        c_re;
		logic signed [29:0]        c_im;
		logic signed [31:0]        x0;
		logic signed [31:0]        y0;
		logic [30:0]               dx;
		logic [30:0]               dy;
		logic [jet_pkg::CNT_W-1:0] iter_max;
	} frame_cfg_t;

	localparam int DIR_ROWS = 53;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// register defaults: far corners escape at once
		'{ROW_PIX, '0, '0, 10'd1023, 10'd1023, 1'b1, 10'd0},
		'{ROW_PIX, '0, '0, 10'd1023, 10'd0,    1'b1, 10'd0},
		'{ROW_PIX, '0, '0, 10'd0,    10'd1023, 1'b1, 10'd0},
		'{ROW_PIX, '0, '0, 10'd0,    10'd0,    1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd255,  10'd255,  1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd256,  10'd511,  1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd400,  10'd300,  1'b0, 10'd0},
		// write to an unmapped index must change nothing
		'{ROW_CFG, REG_UNUSED, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd256,  10'd256,  1'b0, 10'd0},
		// all-zero frame and constant: z stays at the origin
		'{ROW_CFG, jet_pkg::REG_C_REAL,   32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_C_IMAG,   32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_X_MIN,    32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_MIN,    32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_X_STEP,   32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_STEP,   32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_MAX_ITER, 32'd10,        '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd0,    10'd0,    1'b1, 10'd0},
		'{ROW_PIX, '0, '0, 10'd1023, 10'd1023, 1'b1, 10'd0},
		// zero limit, then a limit above the ceiling: bounded either way
		'{ROW_CFG, jet_pkg::REG_MAX_ITER, 32'd0,         '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd512,  10'd512,  1'b1, 10'd0},
		'{ROW_CFG, jet_pkg::REG_MAX_ITER, 32'd1023,      '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd7,    10'd9,    1'b1, 10'd0},
		// start point saturates to the 32-bit range
		'{ROW_CFG, jet_pkg::REG_X_MIN,    32'h7FFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_X_STEP,   32'h7FFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_MIN,    32'h8000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_STEP,   32'h7FFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd1023, 10'd0,    1'b1, 10'd0},
		'{ROW_PIX, '0, '0, 10'd0,    10'd1023, 1'b1, 10'd0},
		// real axis at 1/128 per column, c at its extremes
		'{ROW_CFG, jet_pkg::REG_X_MIN,    32'hE000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_X_STEP,   32'h0020_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_MIN,    32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_STEP,   32'h0000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_C_REAL,   32'h1000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_C_IMAG,   32'hF000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_MAX_ITER, 32'd1000,      '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd0,    10'd0,    1'b0, 10'd0},   // |z|^2 exactly 4
		'{ROW_PIX, '0, '0, 10'd1023, 10'd5,    1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd512,  10'd0,    1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd384,  10'd0,    1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd256,  10'd0,    1'b0, 10'd0},
		'{ROW_CFG, jet_pkg::REG_C_REAL,   32'hF000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_C_IMAG,   32'h1000_0000, '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd300,  10'd0,    1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd600,  10'd0,    1'b0, 10'd0},
		// a familiar Julia frame over [-2,2)^2
		'{ROW_CFG, jet_pkg::REG_Y_MIN,    32'hE000_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_X_STEP,   32'h0010_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_Y_STEP,   32'h0010_0000, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_C_REAL,   32'hF333_3333, '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_C_IMAG,   32'd41875931,  '0, '0, 1'b0, '0},
		'{ROW_CFG, jet_pkg::REG_MAX_ITER, 32'd60,        '0, '0, 1'b0, '0},
		'{ROW_PIX, '0, '0, 10'd512,  10'd512,  1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd700,  10'd300,  1'b0, 10'd0},
		'{ROW_PIX, '0, '0, 10'd100,  10'd900,  1'b0, 10'd0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [jet_pkg::IDX_W-1:0] cfg_idx;
	logic [jet_pkg::CFG_W-1:0] cfg_data;

	jet_pix_if pix_bus ();
	jet_cnt_if cnt_bus ();

	frame_cfg_t   frame_cfg;
	pixel_count_t pending_counts [$];
	pixel_count_t head;
	int           mismatches;
	int           quiet_cycles;
	int           send_idle_pct;
	int           recv_idle_pct;

	julia_escape_time_pixel u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix_in   (pix_bus),
		.cnt_out  (cnt_bus)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clip32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// escape-time count of one pixel under the shadow config
	function automatic logic [jet_pkg::CNT_W-1:0] escape_count(
			input logic [jet_pkg::COORD_W-1:0] px,
			input logic [jet_pkg::COORD_W-1:0] py);
		longint          zr, zi, ar, ai, swap, xterm;
		longint unsigned ur, ui, xx, yy;
		int unsigned     ix, iy, lim, n;
		ix  = (px >= jet_pkg::MAX_DIM) ? jet_pkg::MAX_DIM - 1 : px;
		iy  = (py >= jet_pkg::MAX_DIM) ? jet_pkg::MAX_DIM - 1 : py;
		lim = (frame_cfg.iter_max > jet_pkg::ITER_LIMIT) ? jet_pkg::ITER_LIMIT
			: frame_cfg.iter_max;
		zr  = clip32(longint'($signed(frame_cfg.x0)) + longint'(ix) * longint'(frame_cfg.dx));
		zi  = clip32(longint'($signed(frame_cfg.y0)) + longint'(iy) * longint'(frame_cfg.dy));
		ar  = longint'($signed(frame_cfg.c_re));
		ai  = longint'($signed(frame_cfg.c_im));
		for (n = 0; n <= lim; n++) begin
			ur = (zr < 0) ? -zr : zr;
			ui = (zi < 0) ? -zi : zi;
			xx = (ur * ur) >> jet_pkg::FRAC_BITS;
			yy = (ui * ui) >> jet_pkg::FRAC_BITS;
			if (xx + yy > (64'd4 << jet_pkg::FRAC_BITS)) return n[jet_pkg::CNT_W-1:0];
			if (n == lim) return '0;
			xterm = (zr * zi) >>> (jet_pkg::FRAC_BITS - 1);
			zr    = longint'(xx) - longint'(yy);
			// c parts trade places every pass
			swap = ar;
			ar   = ai;
			ai   = swap;
			zr   = clip32(zr + ar);
			zi   = clip32(xterm + ai);
		end
		return '0;
	endfunction

	// one register write, mirrored into the shadow config; cfg_we stays up
	task automatic cfg_write(input logic [jet_pkg::IDX_W-1:0] idx,
			input logic [jet_pkg::CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			jet_pkg::REG_C_REAL:   frame_cfg.c_re     = data[29:0];
			jet_pkg::REG_C_IMAG:   frame_cfg.c_im     = data[29:0];
			jet_pkg::REG_X_MIN:    frame_cfg.x0       = data;
			jet_pkg::REG_Y_MIN:    frame_cfg.y0       = data;
			jet_pkg::REG_X_STEP:   frame_cfg.dx       = data[30:0];
			jet_pkg::REG_Y_STEP:   frame_cfg.dy       = data[30:0];
			jet_pkg::REG_MAX_ITER: frame_cfg.iter_max = data[jet_pkg::CNT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold off the sender until every count has come back
	task automatic wait_all_counts();
		pix_bus.valid <= 1'b0;
		while (pending_counts.size() != 0) @(posedge clk);
	endtask

	// one pixel beat; valid is left high so the next beat can follow at once
	task automatic send_pixel(input logic [jet_pkg::COORD_W-1:0] px,
			input logic [jet_pkg::COORD_W-1:0] py,
			input logic typed, input logic [jet_pkg::CNT_W-1:0] count);
		pixel_count_t entry;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.col   <= px;
		pix_bus.row   <= py;
		do @(posedge clk); while (!pix_bus.ready);
		entry.col   = px;
		entry.row   = py;
		entry.count = typed ? count : escape_count(px, py);
		pending_counts.push_back(entry);
	endtask

	// frame origin and step along one axis
	task automatic pick_axis(output logic [jet_pkg::CFG_W-1:0] origin,
			output logic [jet_pkg::CFG_W-1:0] step);
		case ($urandom_range(0, 3))
			0, 1: begin
				// origin near -2.0, 2.0 to 8.0 across the frame
				origin = -Q_TWO + (int'($urandom_range(0, 1 << 24)) - (1 << 23));
				step   = $urandom_range(1 << 19, 1 << 21);
			end
			2: begin
				// zoomed near the boundary
				origin = int'($urandom_range(0, 2 * Q_ONE)) - 3 * Q_ONE / 2;
				step   = $urandom_range(0, 1 << 18);
			end
			default: begin
				origin = $urandom();
				step   = $urandom() & 32'h7FFF_FFFF;
			end
		endcase
	endtask

	// rewrite every register for a new random frame
	task automatic load_random_frame(input bit deep);
		int                        c_re, c_im;
		logic [jet_pkg::CFG_W-1:0] x0, y0, dx, dy;
		int unsigned               iters;
		c_re = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
		c_im = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
		if ($urandom_range(0, 7) == 0) c_re = ($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE;
		if ($urandom_range(0, 7) == 0) c_im = ($urandom_range(0, 1) != 0) ? Q_ONE : -Q_ONE;
		pick_axis(x0, dx);
		pick_axis(y0, dy);
		if (deep) begin
			case ($urandom_range(0, 2))
				0:       iters = jet_pkg::ITER_LIMIT;
				1:       iters = 1023;
				default: iters = $urandom_range(900, 1023);
			endcase
		end else begin
			iters = $urandom_range(10, 80);
		end
		cfg_write(jet_pkg::REG_C_REAL, c_re);
		cfg_write(jet_pkg::REG_C_IMAG, c_im);
		cfg_write(jet_pkg::REG_X_MIN, x0);
		cfg_write(jet_pkg::REG_Y_MIN, y0);
		cfg_write(jet_pkg::REG_X_STEP, dx);
		cfg_write(jet_pkg::REG_Y_STEP, dy);
		cfg_write(jet_pkg::REG_MAX_ITER, iters);
		cfg_we <= 1'b0;
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		cnt_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// count beats against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && cnt_bus.valid && cnt_bus.ready) begin
			if (pending_counts.size() == 0) begin
				$display("%0t: count beat with nothing expected: expected none, actual %0d",
					$time, cnt_bus.iteration_count);
				mismatches++;
			end else begin
				head = pending_counts.pop_front();
				if (cnt_bus.iteration_count !== head.count) begin
					$display("%0t: iteration_count of col %0d row %0d: expected %0d, actual %0d",
						$time, head.col, head.row, head.count, cnt_bus.iteration_count);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((pix_bus.valid && pix_bus.ready) || (cnt_bus.valid && cnt_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int  phase;
		int  beats;
		bit  deep;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_idx       <= '0;
		cfg_data      <= '0;
		pix_bus.valid <= 1'b0;
		pix_bus.col   <= '0;
		pix_bus.row   <= '0;
		send_idle_pct = 12;
		recv_idle_pct = 59;

		// shadow of the reset values
		frame_cfg.c_re     = 30'sd80530637;
		frame_cfg.c_im     = 30'sd134217728;
		frame_cfg.x0       = -32'sd268435456;
		frame_cfg.y0       = -32'sd268435456;
		frame_cfg.dx       = 31'd1050628;
		frame_cfg.dy       = 31'd1050628;
		frame_cfg.iter_max = 10'd200;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].kind == ROW_CFG) begin
				wait_all_counts();
				cfg_write(DIR_TAB[i].idx, DIR_TAB[i].data);
			end else begin
				cfg_we <= 1'b0;
				send_pixel(DIR_TAB[i].col, DIR_TAB[i].row, DIR_TAB[i].typed, DIR_TAB[i].count);
			end
		end

		// random frames: receiver idles most first, then sender, then neither
		for (phase = 0; phase < 12; phase++) begin
			deep = (phase % 4 == 3);
			wait_all_counts();
			case (phase / 4)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_random_frame(deep);
			beats = deep ? 15 : 130;
			repeat (beats) begin
				send_pixel(jet_pkg::COORD_W'($urandom_range(0, 1023)),
					jet_pkg::COORD_W'($urandom_range(0, 1023)), 1'b0, '0);
			end
		end

		wait_all_counts();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_counts.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
